[rtl/core/slr_pkg.sv]
// shared types and constants of the subtractive lagged random core
package slr_pkg;

    localparam int WORD_W     = 30;
    localparam int SEED_W     = 28;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam int RING_LEN   = 55;
    localparam int JUMP       = 21;
    localparam int TRAIL_POS  = 31;
    localparam int WARM_STEPS = 4 * RING_LEN;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam word_t MODULUS  = WORD_W'(1000000000);
    localparam word_t MAGIC    = WORD_W'(161803398);
    localparam word_t FIRST_PREV = WORD_W'(1);

    localparam cnt_t SCATTER_LAST = CNT_W'(RING_LEN - 1);
    localparam cnt_t WARM_LAST    = CNT_W'(WARM_STEPS - 1);

    localparam logic KIND_NEXT   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCATTER,
        ST_ALIGN,
        ST_WARM,
        ST_GEN
    } state_t;

    // step: every cell takes its right neighbor; jump: every cell takes the cell JUMP ahead
    typedef struct packed {
        logic step;
        logic jump;
    } shift_ctrl_t;

endpackage

[rtl/core/subtractive_lagged_random_core.sv]
// top level: lag ring of 55 cells, shared modular subtractor and sequencer
//
//  channel | dir | fields (low bit up)           | accepted when
//  s_*     | in  | tdata: seed[27:0]; tuser: kind | s_tvalid && s_tready
//  m_*     | out | tdata: value[29:0]             | m_tvalid && m_tready
//
// a plain request is one ring rotation with one subtraction
// a reseed (or the first request after reset) runs the accept cycle that
// forms the seed word, then 55 scatter steps, one alignment step, 220 warm-up steps
// and the request itself, one ring step each
// the result sits in an output register; a new item is taken while it waits
// unless the block is rebuilding the ring or the held result is not being taken
// reset clears the sequencer, the seeded flag and the output valid flag; the ring holds no reset value
module subtractive_lagged_random_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [slr_pkg::IN_DATA_W-1:0]  s_tdata,  // seed[27:0], zero fill
    input  logic                           s_tuser,  // kind[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slr_pkg::OUT_DATA_W-1:0] m_tdata   // value[29:0], zero fill
);
    import slr_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   cnt_reg;
    cnt_t   cnt_next;
    logic   seeded_reg;
    logic   seeded_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    word_t  out_data_reg;
    word_t  out_data_next;
    word_t  cur_reg;
    word_t  cur_next;
    word_t  prev_reg;
    word_t  prev_next;

    word_t       ring [RING_LEN];
    word_t       step_src [RING_LEN];
    word_t       jump_src [RING_LEN];
    word_t       head;
    word_t       sub_a;
    word_t       sub_b;
    word_t       sub_y;
    shift_ctrl_t ctrl;
    logic        accept;
    logic        out_free;
    logic        reseed;
    logic        gen;
    word_t       seed_word;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign reseed    = (s_tuser == KIND_RESEED) || !seeded_reg;
    assign seed_word = WORD_W'(s_tdata[SEED_W-1:0]);

    slr_sub u_sub (
        .a (sub_a),
        .b (sub_b),
        .y (sub_y)
    );

    // cell 0 is the lead word, cell TRAIL_POS the trail word; head is what re-enters the ring
    for (genvar k = 0; k < RING_LEN; k++)
    begin : g_cell
        localparam int JK = (k + JUMP) % RING_LEN;

        if (k == RING_LEN - 1)
        begin : g_step_head
            assign step_src[k] = head;
        end
        else
        begin : g_step_next
            assign step_src[k] = ring[k+1];
        end

        if (JK == 0)
        begin : g_jump_head
            assign jump_src[k] = head;
        end
        else
        begin : g_jump_next
            assign jump_src[k] = ring[JK];
        end

        slr_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .step_in (step_src[k]),
            .jump_in (jump_src[k]),
            .word    (ring[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && reseed)
                begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER:
            begin
                if (cnt_reg == SCATTER_LAST)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                state_next = ST_WARM;
            end
            ST_WARM:
            begin
                if (cnt_reg == WARM_LAST)
                begin
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        head           = ring[0];
        sub_a          = ring[0];
        sub_b          = ring[TRAIL_POS];
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        gen            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (reseed)
                    begin
                        sub_a     = MAGIC;
                        sub_b     = seed_word;
                        cur_next  = sub_y;
                        prev_next = FIRST_PREV;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        gen = 1'b1;
                    end
                end
            end
            ST_SCATTER:
            begin
                ctrl.jump = 1'b1;
                sub_a     = cur_reg;
                sub_b     = prev_reg;
                // first scatter step drops the seed word into slot 55
                if (cnt_reg == '0)
                begin
                    head = cur_reg;
                end
                else
                begin
                    head      = prev_reg;
                    prev_next = sub_y;
                    cur_next  = prev_reg;
                end
                cnt_next = (cnt_reg == SCATTER_LAST) ? '0 : cnt_reg + 1'b1;
            end
            ST_ALIGN:
            begin
                // plain rotation so that cell 0 holds slot 1
                ctrl.step = 1'b1;
                head      = ring[0];
                cnt_next  = '0;
            end
            ST_WARM:
            begin
                ctrl.step = 1'b1;
                head      = sub_y;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    gen         = 1'b1;
                    seeded_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase

        if (gen)
        begin
            ctrl.step      = 1'b1;
            head           = sub_y;
            out_valid_next = 1'b1;
            out_data_next  = sub_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

[rtl/core/slr_cell.sv]
// one word of the rotating lag ring
module slr_cell (
    input  logic                clk,
    input  slr_pkg::shift_ctrl_t ctrl,
    input  slr_pkg::word_t      step_in,
    input  slr_pkg::word_t      jump_in,
    output slr_pkg::word_t      word
);
    import slr_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.jump)
        begin
            word_next = jump_in;
        end
        else if (ctrl.step)
        begin
            word_next = step_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

[rtl/core/slr_sub.sv]
// subtraction modulo 10^9 for operands already below the modulus
module slr_sub (
    input  slr_pkg::word_t a,
    input  slr_pkg::word_t b,
    output slr_pkg::word_t y
);
    import slr_pkg::*;

    logic [WORD_W:0] diff;

    always_comb
    begin
        diff = {1'b0, a} - {1'b0, b};
        if (diff[WORD_W])
        begin
            y = diff[WORD_W-1:0] + MODULUS;
        end
        else
        begin
            y = diff[WORD_W-1:0];
        end
    end

endmodule

[rtl/core/slr_checker.sv]
// port checker for the subtractive lagged random core, bound to the top level
module slr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [slr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import slr_pkg::*;

    // a held result keeps its value until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // every value stays below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[WORD_W-1:0] < MODULUS)
        else $error("value not below 10^9");

    // padding bits above the value stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:WORD_W] == '0)
        else $error("nonzero padding in result");

    // after an item is taken, either its result shows or the block stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("item taken without result or busy");

endmodule

bind subtractive_lagged_random_core slr_checker u_slr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_subtractive_lagged_random_core.sv]
// testbench of the subtractive lagged random core: stream stimulus with a value scoreboard
module tb_subtractive_lagged_random_core;

    import slr_pkg::*;

    localparam logic [SEED_W-1:0] SEED_MAX  = {SEED_W{1'b1}};
    localparam logic [SEED_W-1:0] SEED_MAG  = SEED_W'(161803398);
    localparam int                RAND_ITEMS = 930;

    // expected values of the generator, worked out from each accepted request
    class ran_value_board;
        word_t       ring [1:RING_LEN];
        int unsigned lead;
        int unsigned trail;
        bit          seeded;
        word_t       due_values [$];
        int unsigned misses;

        function new();
            lead   = 0;
            trail  = TRAIL_POS;
            seeded = 1'b0;
            misses = 0;
        endfunction

        // a - b modulo 10^9, both operands already below the modulus or the magic word
        function word_t mod_sub(word_t a, word_t b);
            if (a >= b)
                return a - b;
            return a - b + MODULUS;
        endfunction

        function void rebuild(logic [SEED_W-1:0] seed);
            word_t cur;
            word_t prev;
            int    slot;
            cur = mod_sub(MAGIC, WORD_W'(seed));
            ring[RING_LEN] = cur;
            prev = FIRST_PREV;
            for (int n = 1; n < RING_LEN; n++)
            begin
                slot = (JUMP * n) % RING_LEN;
                ring[slot] = prev;
                prev = mod_sub(cur, prev);
                cur = ring[slot];
            end
            for (int pass = 0; pass < 4; pass++)
            begin
                for (int n = 1; n <= RING_LEN; n++)
                    ring[n] = mod_sub(ring[n], ring[1 + (n + 30) % RING_LEN]);
            end
            lead   = 0;
            trail  = TRAIL_POS;
            seeded = 1'b1;
        endfunction

        function void take_request(logic kind, logic [SEED_W-1:0] seed);
            word_t v;
            if (kind == KIND_RESEED || !seeded)
                rebuild(seed);
            lead  = (lead >= RING_LEN) ? 1 : lead + 1;
            trail = (trail >= RING_LEN) ? 1 : trail + 1;
            v = mod_sub(ring[lead], ring[trail]);
            ring[lead] = v;
            due_values.push_back(v);
        endfunction

        function void report(string msg);
            misses++;
            if (misses <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void take_value(logic [OUT_DATA_W-1:0] data);
            word_t want;
            if (due_values.size() == 0)
            begin
                report($sformatf("value %0d arrived with no request pending",
                                 data[WORD_W-1:0]));
                return;
            end
            want = due_values.pop_front();
            if (data[WORD_W-1:0] !== want)
                report($sformatf("value expected %0d, got %0d", want, data[WORD_W-1:0]));
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = KIND_NEXT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  calm     = 1'b0;

    ran_value_board board = new();

    subtractive_lagged_random_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // offers one request and returns at the edge where it is taken
    task automatic send_request(input logic kind, input logic [SEED_W-1:0] seed);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_DATA_W - SEED_W){1'b0}}, seed};
        do
            @(posedge clk);
        while (!s_tready);
        board.take_request(kind, seed);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_values();
        if (board.due_values.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (board.due_values.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [SEED_W-1:0] pick_seed();
        case ($urandom_range(0, 3))
            0: return SEED_W'($urandom_range(0, 161803398));
            1: return SEED_W'($urandom_range(161803399, 268435455));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return SEED_MAG;
                    2: return SEED_MAG + 1'b1;
                    3: return SEED_MAG - 1'b1;
                    default: return SEED_MAX;
                endcase
            end
            default: return SEED_W'($urandom());
        endcase
    endfunction

    // result side: random stall bursts, one long hold-off, none in the calm tail
    initial
    begin : value_sink
        int idle_left;
        int hold_left;
        int idle_pct;
        int taken;
        int cyc;
        bit held;
        bit ready;
        idle_left = 0;
        hold_left = 0;
        idle_pct  = 20;
        taken     = 0;
        cyc       = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.take_value(m_tdata);
                taken++;
            end
            cyc++;
            if (cyc % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 60;
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (!held && taken >= 200)
            begin
                // long hold-off so the block backs up and stalls its input
                held = 1'b1;
                hold_left = 400;
                ready = 1'b0;
            end
            else if (calm)
                ready = 1'b1;
            else if (idle_left > 0)
            begin
                idle_left--;
                ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                idle_left = $urandom_range(1, 10) - 1;
                ready = 1'b0;
            end
            else
                ready = 1'b1;
            m_tready <= ready;
        end
    end

    initial
    begin : request_source
        int gap_pct;
        logic kind;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first request after reset is a next value yet still seeds the ring
        send_request(KIND_NEXT, '0);
        send_request(KIND_NEXT, SEED_MAX);
        send_request(KIND_NEXT, SEED_W'(28'h5555555));
        sender_gap($urandom_range(1, 10));
        // seed equal to the magic word leaves a zero difference
        send_request(KIND_RESEED, SEED_MAG);
        send_request(KIND_NEXT, SEED_W'(28'hAAAAAAA));
        // seeds above the magic word wrap once
        send_request(KIND_RESEED, SEED_MAG + 1'b1);
        send_request(KIND_RESEED, SEED_MAX);
        send_request(KIND_NEXT, '0);
        send_request(KIND_RESEED, SEED_MAG - 1'b1);
        sender_gap($urandom_range(1, 10));
        send_request(KIND_RESEED, SEED_W'(28'hAAAAAAA));
        send_request(KIND_RESEED, SEED_W'(28'h5555555));
        send_request(KIND_RESEED, SEED_W'(1));
        send_request(KIND_RESEED, '0);
        for (int i = 0; i < 8; i++)
            send_request(KIND_NEXT, SEED_W'($urandom()));

        gap_pct = 20;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            end
            if (i == RAND_ITEMS / 2)
                drain_values();
            if (i == RAND_ITEMS - 100)
                calm <= 1'b1;
            kind = ($urandom_range(0, 31) == 0) ? KIND_RESEED : KIND_NEXT;
            send_request(kind, pick_seed());
            if (i < RAND_ITEMS - 100 && $urandom_range(0, 99) < gap_pct)
                sender_gap($urandom_range(1, 10));
        end

        drain_values();
        repeat (20) @(posedge clk);
        if (board.misses == 0 && board.due_values.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #(14_400_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
